// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ring modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CHR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ring assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CHR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ring assertion failed");

`endif

// ===== rtl/chr_pkg.sv =====
// Package of the consistent hash ring: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package chr_pkg;

  localparam int MaxServersDef = 1024;
  localparam int ReplicasDef   = 2;
  localparam int LimitW        = 11;
  localparam int IdW           = 48;
  localparam int HashW         = 64;
  localparam int TagW16        = 16;
  localparam logic [LimitW-1:0] LimitRst = 11'd4;
  localparam logic [31:0]       MixMult  = 32'h045d9f3b;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DIST   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_IDX   = 2'd0,
    RD_IDXM1 = 2'd1,
    RD_MID   = 2'd2,
    RD_POS   = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SHIFT   = 2'd0,
    WR_COMPACT = 2'd1,
    WR_NEW     = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    mix_start;
    logic    key_load;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_cnt;
    logic    w_inc;
    logic    found_set;
    logic    tag_inc;
    logic    cnt_inc;
    logic    cnt_from_w;
    logic    srv_inc;
    logic    srv_dec;
    logic    bs_init;
    logic    bs_lo;
    logic    bs_hi;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    set_status;
    status_e status;
    logic    res_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic cnt_zero;
    logic id_match;
    logic idx_last;
    logic idx_one;
    logic shift;
    logic mix_done;
    logic lo_lt_hi;
    logic rh_lt_key;
    logic found;
    logic tag_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/chr_mix.sv =====
// Multi-cycle 64-bit xorshift-multiply hash unit with one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module chr_mix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] x_i,
  output logic             done_o,
  output logic [63:0]      hash_o
);

  logic [63:0] x_q, x_d;
  logic [63:0] plo_q, plo_d;
  logic [31:0] phi_q, phi_d;
  logic [3:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] mul_a;
  logic [63:0] prod;

  // Steps 1 and 5 take the low half, steps 2 and 6 the high half.
  assign mul_a = (step_q == 4'd2 || step_q == 4'd6) ? x_q[63:32] : x_q[31:0];
  assign prod  = 64'(mul_a) * 64'(chr_pkg::MixMult);

  always_comb begin
    x_d    = x_q;
    plo_d  = plo_q;
    phi_d  = phi_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      step_d = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 4'd1;
      case (step_q)
        4'd0, 4'd4: x_d = x_q ^ (x_q >> 16);
        4'd1, 4'd5: plo_d = prod;
        4'd2, 4'd6: phi_d = prod[31:0];
        4'd3, 4'd7: x_d = plo_q + {phi_q, 32'd0};
        4'd8: begin
          x_d    = x_q ^ (x_q >> 16);
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    plo_q <= plo_d;
    phi_q <= phi_d;
  end

  assign done_o = done_q;
  assign hash_o = x_q;

  `CHR_ASSERT_IMP(a_start_idle, start_i, !busy_q)
  `CHR_ASSERT_NXT(a_done_pulse, done_q, !done_q)

endmodule
`default_nettype wire

// ===== rtl/chr_ctrl.sv =====
// Controller state machine that sequences every ring operation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module chr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire chr_pkg::stat_t stat_i,
  output chr_pkg::cmd_t       cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DISP     = 18'h00002,
    S_PR_RD    = 18'h00004,
    S_PR_CMP   = 18'h00008,
    S_ADD_MIX  = 18'h00010,
    S_ADD_WAIT = 18'h00020,
    S_INS_RD   = 18'h00040,
    S_INS_CMP  = 18'h00080,
    S_INS_WR   = 18'h00100,
    S_RM_RD    = 18'h00200,
    S_RM_CMP   = 18'h00400,
    S_RM_END   = 18'h00800,
    S_DS_WAIT  = 18'h01000,
    S_BS_CHK   = 18'h02000,
    S_BS_CMP   = 18'h04000,
    S_DS_OUT   = 18'h08000,
    S_FIN      = 18'h10000,
    S_SPARE    = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  chr_pkg::cmd_t cmd;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.rd_sel = chr_pkg::RD_IDX;
    cmd.wr_sel = chr_pkg::WR_SHIFT;
    cmd.status = chr_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          chr_pkg::OP_ADD: begin
            if (stat_i.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = chr_pkg::ST_FULL;
              state_d        = S_FIN;
            end else if (stat_i.cnt_zero) begin
              state_d = S_ADD_MIX;
            end else begin
              state_d = S_PR_RD;
            end
          end
          chr_pkg::OP_REMOVE: begin
            if (stat_i.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = chr_pkg::ST_ABSENT;
              state_d        = S_FIN;
            end else begin
              state_d = S_RM_RD;
            end
          end
          chr_pkg::OP_DIST: begin
            if (stat_i.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = chr_pkg::ST_EMPTY;
              state_d        = S_FIN;
            end else begin
              cmd.mix_start = 1'b1;
              state_d       = S_DS_WAIT;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_PR_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = S_PR_CMP;
      end
      S_PR_CMP: begin
        if (stat_i.id_match) begin
          cmd.set_status = 1'b1;
          cmd.status     = chr_pkg::ST_PRESENT;
          state_d        = S_FIN;
        end else if (stat_i.idx_last) begin
          state_d = S_ADD_MIX;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_PR_RD;
        end
      end
      S_ADD_MIX: begin
        cmd.mix_start = 1'b1;
        state_d       = S_ADD_WAIT;
      end
      S_ADD_WAIT: begin
        if (stat_i.mix_done) begin
          cmd.key_load = 1'b1;
          cmd.idx_cnt  = 1'b1;
          state_d      = stat_i.cnt_zero ? S_INS_WR : S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = chr_pkg::RD_IDXM1;
        state_d    = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (stat_i.shift) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = chr_pkg::WR_SHIFT;
          cmd.idx_dec = 1'b1;
          state_d     = stat_i.idx_one ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = chr_pkg::WR_NEW;
        cmd.cnt_inc = 1'b1;
        if (stat_i.tag_last) begin
          cmd.srv_inc = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd.tag_inc = 1'b1;
          state_d     = S_ADD_MIX;
        end
      end
      S_RM_RD: begin
        cmd.rd_en = 1'b1;
        state_d   = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (stat_i.id_match) begin
          cmd.found_set = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = chr_pkg::WR_COMPACT;
          cmd.w_inc  = 1'b1;
        end
        if (stat_i.idx_last) begin
          state_d = S_RM_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_RM_RD;
        end
      end
      S_RM_END: begin
        if (stat_i.found) begin
          cmd.cnt_from_w = 1'b1;
          cmd.srv_dec    = 1'b1;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = chr_pkg::ST_ABSENT;
        end
        state_d = S_FIN;
      end
      S_DS_WAIT: begin
        if (stat_i.mix_done) begin
          cmd.key_load = 1'b1;
          cmd.bs_init  = 1'b1;
          state_d      = S_BS_CHK;
        end
      end
      S_BS_CHK: begin
        cmd.rd_en = 1'b1;
        if (stat_i.lo_lt_hi) begin
          cmd.rd_sel = chr_pkg::RD_MID;
          state_d    = S_BS_CMP;
        end else begin
          cmd.rd_sel = chr_pkg::RD_POS;
          state_d    = S_DS_OUT;
        end
      end
      S_BS_CMP: begin
        if (stat_i.rh_lt_key) begin
          cmd.bs_lo = 1'b1;
        end else begin
          cmd.bs_hi = 1'b1;
        end
        state_d = S_BS_CHK;
      end
      S_DS_OUT: begin
        cmd.res_load = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `CHR_ASSERT_NXT(a_beat_leaves_idle, in_valid_i && in_ready_o, state_q == S_DISP)
  `CHR_ASSERT_IMP(a_load_free, cmd.out_load, !out_valid_q || out_ready_i)

endmodule
`default_nettype wire

// ===== rtl/chr_dp.sv =====
// Datapath of the ring: node memory, counters, search registers and result registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module chr_dp #(
  parameter int MAX_SERVERS = chr_pkg::MaxServersDef,
  parameter int REPLICAS    = chr_pkg::ReplicasDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [chr_pkg::LimitW-1:0] cfg_data_i,
  input  wire logic [1:0]                 in_op_i,
  input  wire logic [31:0]                in_addr_i,
  input  wire logic [15:0]                in_port_i,
  input  wire chr_pkg::cmd_t              cmd_i,
  output chr_pkg::stat_t                  stat_o,
  output logic [2:0]                      out_status_o,
  output logic [31:0]                     out_addr_o,
  output logic [15:0]                     out_port_o
);

  localparam int Slots = MAX_SERVERS * REPLICAS;
  localparam int AW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CW    = $clog2(Slots + 1);
  localparam int SW    = $clog2(MAX_SERVERS + 1);
  localparam int LW    = (SW > chr_pkg::LimitW) ? SW : chr_pkg::LimitW;
  localparam int TW    = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
  localparam int EW    = chr_pkg::HashW + chr_pkg::IdW;

  logic [EW-1:0] mem [Slots];
  logic [EW-1:0] rdata_q;

  logic [chr_pkg::LimitW-1:0] limit_q;
  chr_pkg::op_e op_q;
  logic [chr_pkg::IdW-1:0]   id_q;
  logic [chr_pkg::HashW-1:0] key_q;
  logic [CW-1:0] idx_q, w_q, cnt_q, lo_q, hi_q;
  logic [SW-1:0] srv_q;
  logic [TW-1:0] tag_q;
  logic          found_q, first_q;
  chr_pkg::status_e res_status_q;
  logic [31:0]   res_addr_q, out_addr_q;
  logic [15:0]   res_port_q, out_port_q;
  logic [2:0]    out_status_q;

  logic [chr_pkg::HashW-1:0] rh, mix_hash, label;
  logic [chr_pkg::IdW-1:0]   rid;
  logic [CW-1:0]             mid, pos;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic [EW-1:0]             wr_data;
  logic [LW-1:0]             lim_ext, lim_eff;
  logic                      mix_done;

  assign rh  = rdata_q[EW-1:chr_pkg::IdW];
  assign rid = rdata_q[chr_pkg::IdW-1:0];
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign pos = (lo_q >= cnt_q) ? '0 : lo_q;
  assign label = {{(chr_pkg::TagW16 - TW){1'b0}}, tag_q, id_q};

  assign lim_ext = LW'(limit_q);
  assign lim_eff = (lim_ext > LW'(MAX_SERVERS)) ? LW'(MAX_SERVERS) : lim_ext;

  chr_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mix_start),
    .x_i     (label),
    .done_o  (mix_done),
    .hash_o  (mix_hash)
  );

  always_comb begin
    case (cmd_i.rd_sel)
      chr_pkg::RD_IDX:   rd_addr = idx_q[AW-1:0];
      chr_pkg::RD_IDXM1: rd_addr = AW'(idx_q - CW'(1));
      chr_pkg::RD_MID:   rd_addr = mid[AW-1:0];
      chr_pkg::RD_POS:   rd_addr = pos[AW-1:0];
      default:           rd_addr = idx_q[AW-1:0];
    endcase
    case (cmd_i.wr_sel)
      chr_pkg::WR_SHIFT: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = rdata_q;
      end
      chr_pkg::WR_COMPACT: begin
        wr_addr = w_q[AW-1:0];
        wr_data = rdata_q;
      end
      chr_pkg::WR_NEW: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = {key_q, id_q};
      end
      default: begin
        wr_addr = idx_q[AW-1:0];
        wr_data = rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= chr_pkg::LimitRst;
      cnt_q   <= '0;
      srv_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_from_w) begin
        cnt_q <= w_q;
      end
      if (cmd_i.srv_inc) begin
        srv_q <= srv_q + SW'(1);
      end else if (cmd_i.srv_dec && srv_q != '0) begin
        srv_q <= srv_q - SW'(1);
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= chr_pkg::op_e'(in_op_i);
      id_q         <= {in_addr_i, 16'd0} ^ {32'd0, in_port_i};
      idx_q        <= '0;
      w_q          <= '0;
      tag_q        <= '0;
      found_q      <= 1'b0;
      res_status_q <= chr_pkg::ST_OK;
      res_addr_q   <= '0;
      res_port_q   <= '0;
    end else begin
      if (cmd_i.key_load) begin
        key_q <= mix_hash;
      end
      if (cmd_i.idx_cnt) begin
        idx_q   <= cnt_q;
        first_q <= 1'b1;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end else if (cmd_i.idx_dec) begin
        idx_q   <= idx_q - CW'(1);
        first_q <= 1'b0;
      end
      if (cmd_i.w_inc) begin
        w_q <= w_q + CW'(1);
      end
      if (cmd_i.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd_i.tag_inc) begin
        tag_q <= tag_q + TW'(1);
      end
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.res_load) begin
        res_addr_q <= rid[47:16];
        res_port_q <= rid[15:0];
      end
    end
    if (cmd_i.bs_init) begin
      lo_q <= '0;
      hi_q <= cnt_q;
    end else if (cmd_i.bs_lo) begin
      lo_q <= mid + CW'(1);
    end else if (cmd_i.bs_hi) begin
      hi_q <= mid;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_port_q   <= res_port_q;
    end
  end

  always_comb begin
    stat_o.op        = op_q;
    stat_o.full      = LW'(srv_q) >= lim_eff;
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.id_match  = (rid == id_q);
    stat_o.idx_last  = ((idx_q + CW'(1)) == cnt_q);
    stat_o.idx_one   = (idx_q == CW'(1));
    // The last node shifts only on a larger hash, the others also on an equal one.
    stat_o.shift     = first_q ? (rh > key_q) : (rh >= key_q);
    stat_o.mix_done  = mix_done;
    stat_o.lo_lt_hi  = (lo_q < hi_q);
    stat_o.rh_lt_key = (rh < key_q);
    stat_o.found     = found_q;
    stat_o.tag_last  = (tag_q == TW'(REPLICAS - 1));
  end

  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;
  assign out_port_o   = out_port_q;

  `CHR_ASSERT_IMP(a_room_on_insert, cmd_i.cnt_inc, cnt_q < CW'(Slots))
  `CHR_ASSERT_IMP(a_read_write_apart, cmd_i.rd_en && cmd_i.wr_en, 1'b0)

endmodule
`default_nettype wire

// ===== rtl/consistent_hash_ring_unit.sv =====
// Consistent hash ring for load balancing.
// Input beats on s_axis carry one request: add a server, remove a server or map a
// client endpoint to a server; every request yields exactly one beat on m_axis.
// The cfg channel writes the server limit; it is always ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// One request is worked on at a time. The node table is one memory with a
// registered read port, so every table access is a read, then a compare:
//   distribute: the hash unit runs, then a binary search over the table finds
//     the node, and its entry is read out for the result beat;
//   add: a presence scan over the nodes, then per replica the hashing and the
//     shifting of the larger nodes to make room;
//   remove: a scan over every node that compacts the remaining entries.
// The result sits in an output register; s_axis becomes ready again as soon as
// that register is loaded, so a stalled receiver holds off only the next result.
// Reset clears the node and server counts and sets the limit to four; the table
// contents need no clearing, since only entries below the node count are read.
`timescale 1ns / 1ps
`default_nettype none
module consistent_hash_ring_unit #(
  parameter int MAX_SERVERS = chr_pkg::MaxServersDef,
  parameter int REPLICAS    = chr_pkg::ReplicasDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_data_i,     // server_limit
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i, // endpoint_address[31:0], endpoint_port[47:32]
  input  wire logic [1:0]  s_axis_tuser_i, // operation[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o, // server_address[31:0], server_port[47:32]
  output logic [2:0]       m_axis_tuser_o  // status[2:0]
);

  chr_pkg::cmd_t  cmd;
  chr_pkg::stat_t stat;
  logic [31:0]    out_addr;
  logic [15:0]    out_port;

  assign cfg_ready_o = 1'b1;

  chr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  chr_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .REPLICAS    (REPLICAS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_op_i      (s_axis_tuser_i),
    .in_addr_i    (s_axis_tdata_i[31:0]),
    .in_port_i    (s_axis_tdata_i[47:32]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_status_o (m_axis_tuser_o),
    .out_addr_o   (out_addr),
    .out_port_o   (out_port)
  );

  assign m_axis_tdata_o = {out_port, out_addr};

endmodule
`default_nettype wire
